/* rtl/texture_nearest_sampler_macros.svh */
// assertion macros for the texture sampler rtl
// no dependencies; included by files that carry concurrent checks
`ifndef TEXTURE_NEAREST_SAMPLER_MACROS_SVH
`define TEXTURE_NEAREST_SAMPLER_MACROS_SVH
`ifndef SYNTHESIS
`define TNS_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("tns assertion failed");
`define TNS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tns assertion failed");
`else
`define TNS_ASSERT(label, clk, rstn, prop)
`define TNS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

/* rtl/tns_pkg.sv */
// shared types and constants of the texture sampler
// no dependencies
`timescale 1ns / 1ps
package tns_pkg;

  // operation codes of a request
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_POINT   = 2'd1;
  localparam logic [1:0] OP_NEAREST = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_SRC16  = 2'd2;

  localparam int DIM_W       = 9;   // width of the size registers and texel coordinates
  localparam int TEXEL_W     = 48;
  localparam int QUEUE_DEPTH = 4;
  localparam int OBUF_DEPTH  = 3;
  localparam int OBUF_CNT_W  = $clog2(OBUF_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_ZERO
  } cmd_e;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             src16;
  } cfg_t;

  typedef struct packed {
    cmd_e               cmd;
    logic [DIM_W-1:0]   x;
    logic [DIM_W-1:0]   y;
    logic [TEXEL_W-1:0] texel;
  } qent_t;

  localparam int QENT_W = $bits(qent_t);

endpackage

/* rtl/tns_in_if.sv */
// request channel of the texture sampler
// no dependencies
`timescale 1ns / 1ps
interface tns_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  operation;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [31:0] coord_u;
  logic signed [31:0] coord_v;
  logic        [15:0] src_blue;
  logic        [15:0] src_green;
  logic        [15:0] src_red;

  modport source (output valid, operation, pos_x, pos_y, coord_u, coord_v,
                  src_blue, src_green, src_red, input ready);
  modport sink (input valid, operation, pos_x, pos_y, coord_u, coord_v,
                src_blue, src_green, src_red, output ready);
endinterface

/* rtl/tns_out_if.sv */
// result channel of the texture sampler
// no dependencies
`timescale 1ns / 1ps
interface tns_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_red;
  logic [15:0] out_green;
  logic [15:0] out_blue;

  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

/* rtl/tns_ram.sv */
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module tns_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (en_i && !we_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

/* rtl/tns_fifo.sv */
// small first-in first-out queue held in flip-flops
// no dependencies
`timescale 1ns / 1ps
module tns_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             wdata_i,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             rdata_o,
  output logic                         valid_o,
  output logic                         full_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_push = push_i && (cnt_q != CNT_W'(DEPTH));
  assign do_pop  = pop_i && (cnt_q != '0);

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rptr_q];
  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign count_o = cnt_q;
endmodule

/* rtl/tns_front.sv */
// request decode: bounds check, channel widening, coordinate clamp and scale
// depends on tns_pkg and tns_in_if
`timescale 1ns / 1ps
module tns_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  tns_in_if.sink               in_if,
  input  tns_pkg::cfg_t        cfg_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output tns_pkg::qent_t       q_ent_o
);
  import tns_pkg::*;

  logic [DIM_W-1:0] eff_w, eff_h, wm1, hm1;
  logic             in_x, in_y, in_tex;
  logic [16:0]      u_cl, v_cl;
  logic [25:0]      prod_u, prod_v;
  logic [9:0]       nx, ny;
  logic [DIM_W-1:0] sx, sy;
  logic [15:0]      wr, wg, wb;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v, input int maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > maxv) begin
      r = DIM_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [16:0] clamp_unit(input logic signed [31:0] c);
    logic [16:0] r;
    if (c[31]) begin
      r = '0;
    end else if (c[30:0] > 31'h10000) begin
      r = 17'h10000;
    end else begin
      r = c[16:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] widen(input logic [15:0] c, input logic src16);
    return src16 ? c : {c[7:0], c[7:0]};
  endfunction

  assign eff_w = eff_dim(cfg_i.width, MAX_WIDTH);
  assign eff_h = eff_dim(cfg_i.height, MAX_HEIGHT);
  assign wm1   = eff_w - 1'b1;
  assign hm1   = eff_h - 1'b1;

  assign in_x   = !in_if.pos_x[15] && ($unsigned(in_if.pos_x) < {7'd0, eff_w});
  assign in_y   = !in_if.pos_y[15] && ($unsigned(in_if.pos_y) < {7'd0, eff_h});
  assign in_tex = in_x && in_y;

  // nearest: clamp to [0,1], scale by size minus one, truncate
  assign u_cl   = clamp_unit(in_if.coord_u);
  assign v_cl   = clamp_unit(in_if.coord_v);
  assign prod_u = 26'(u_cl) * 26'(wm1);
  assign prod_v = 26'(v_cl) * 26'(hm1);
  assign nx     = prod_u[25:16];
  assign ny     = prod_v[25:16];
  assign sx     = (nx >= {1'b0, eff_w}) ? wm1 : nx[DIM_W-1:0];
  assign sy     = (ny >= {1'b0, eff_h}) ? hm1 : ny[DIM_W-1:0];

  assign wr = widen(in_if.src_red, cfg_i.src16);
  assign wg = widen(in_if.src_green, cfg_i.src16);
  assign wb = widen(in_if.src_blue, cfg_i.src16);

  assign in_if.ready = !q_full_i;

  always_comb begin
    q_ent_o.cmd   = CMD_ZERO;
    q_ent_o.x     = in_if.pos_x[DIM_W-1:0];
    q_ent_o.y     = in_if.pos_y[DIM_W-1:0];
    q_ent_o.texel = {wr, wg, wb};
    q_push_o      = 1'b0;
    unique case (in_if.operation)
      OP_LOAD: begin
        q_ent_o.cmd = CMD_WRITE;
        q_push_o    = in_tex;
      end
      OP_POINT: begin
        q_ent_o.cmd = in_tex ? CMD_READ : CMD_ZERO;
        q_push_o    = 1'b1;
      end
      OP_NEAREST: begin
        q_ent_o.cmd = CMD_READ;
        q_ent_o.x   = sx;
        q_ent_o.y   = sy;
        q_push_o    = 1'b1;
      end
      default: begin
        q_push_o = 1'b0;
      end
    endcase
    q_push_o = q_push_o && in_if.valid && !q_full_i;
  end
endmodule

/* rtl/tns_back.sv */
// texel store access and result buffering
// depends on tns_pkg, tns_ram, tns_fifo, tns_out_if and the macro header
`timescale 1ns / 1ps
`include "texture_nearest_sampler_macros.svh"
module tns_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  tns_pkg::qent_t       q_ent_i,
  output logic                 q_pop_o,
  tns_out_if.source            out_if
);
  import tns_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ADDR_W-1:0]     addr;
  logic                  ram_en, ram_we, is_write;
  logic [TEXEL_W-1:0]    rd_data, res_data, obuf_data;
  logic                  pend_q, pend_d, pend_zero_q, pend_zero_d;
  logic [OBUF_CNT_W-1:0] occ;
  logic                  credit_ok, obuf_valid, obuf_full, obuf_pop;

  assign addr     = ADDR_W'(32'(q_ent_i.y) * MAX_WIDTH + 32'(q_ent_i.x));
  assign is_write = (q_ent_i.cmd == CMD_WRITE);

  // room for the pending read plus one more in the result buffer
  assign credit_ok = (3'(occ) + 3'(pend_q)) <= 3'(OBUF_DEPTH - 1);
  assign q_pop_o   = q_valid_i && (is_write || credit_ok);

  assign ram_en = q_pop_o && (q_ent_i.cmd != CMD_ZERO);
  assign ram_we = is_write;

  assign pend_d      = q_pop_o && !is_write;
  assign pend_zero_d = (q_ent_i.cmd == CMD_ZERO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_zero_q <= pend_zero_d;
  end

  tns_ram #(
    .WIDTH (TEXEL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (addr),
    .wdata_i (q_ent_i.texel),
    .rdata_o (rd_data)
  );

  assign res_data = pend_zero_q ? '0 : rd_data;
  assign obuf_pop = out_if.valid && out_if.ready;

  tns_fifo #(
    .WIDTH (TEXEL_W),
    .DEPTH (OBUF_DEPTH)
  ) u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pend_q),
    .wdata_i (res_data),
    .pop_i   (obuf_pop),
    .rdata_o (obuf_data),
    .valid_o (obuf_valid),
    .full_o  (obuf_full),
    .count_o (occ)
  );

  assign out_if.valid     = obuf_valid;
  assign out_if.out_red   = obuf_data[47:32];
  assign out_if.out_green = obuf_data[31:16];
  assign out_if.out_blue  = obuf_data[15:0];

  `TNS_ASSERT(a_obuf_no_overflow, clk_i, rst_ni, !(pend_q && obuf_full && !obuf_pop))
  `TNS_ASSERT_NEXT(a_write_no_result, clk_i, rst_ni, q_pop_o && is_write, !pend_q)
  `TNS_ASSERT_NEXT(a_read_returns, clk_i, rst_ni, q_pop_o && !is_write, pend_q)
endmodule

/* rtl/texture_nearest_sampler.sv */
// top level of the nearest texture sampler: config registers, decode, queue, store
// depends on tns_pkg, tns_in_if, tns_out_if, tns_front, tns_fifo, tns_back
`timescale 1ns / 1ps
// usage
// - in_if carries requests: load texel, point sample or nearest sample.
//   a request is taken when valid and ready are both high
// - out_if returns one texel (red, green, blue, 16-bit unorm) per sample,
//   in request order; loads and unknown operations return nothing
// - cfg_we_i / cfg_idx_i / cfg_data_i write width, height and the 16-bit
//   source flag; write only while no request is in flight
// - throughput: one request per cycle while out_if keeps ready high, set by the single port of
//   the texel ram, which does one write or one read each cycle
// - a taken sample passes the request queue, the ram read and the result buffer
//   on its way to out_if
// - reset clears the config to 256 x 256, 8-bit source, and empties the
//   queues; the texel ram is not cleared, texels are undefined until loaded
// - when out_if stalls the 3-entry result buffer fills, the back end stops
//   issuing reads, the 4-entry request queue fills and in_if drops ready
module texture_nearest_sampler #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tns_in_if.sink     in_if,
  tns_out_if.source  out_if,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [8:0] cfg_data_i
);
  import tns_pkg::*;

  cfg_t  cfg_q, cfg_d;
  logic  q_push, q_pop, q_valid, q_full;
  qent_t q_wr_ent;
  logic [QENT_W-1:0] q_rdata;

  // config register write decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH:  cfg_d.width  = cfg_data_i;
        CFG_HEIGHT: cfg_d.height = cfg_data_i;
        CFG_SRC16:  cfg_d.src16  = cfg_data_i[0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= DIM_W'(256);
      cfg_q.height <= DIM_W'(256);
      cfg_q.src16  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front end: classify, bounds check, widen channels, clamp and scale coords
  tns_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .in_if    (in_if),
    .cfg_i    (cfg_q),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_ent_o  (q_wr_ent)
  );

  // decoupling queue between decode and store access
  tns_fifo #(
    .WIDTH (QENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wr_ent),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .valid_o (q_valid),
    .full_o  (q_full),
    .count_o ()
  );

  // back end: texel ram access and result buffering
  tns_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_ent_i   (qent_t'(q_rdata)),
    .q_pop_o   (q_pop),
    .out_if    (out_if)
  );
endmodule

/* bench/tb_texture_nearest_sampler.sv */
// self-checking bench for texture_nearest_sampler: directed and random request traffic
// mirrors the texel store and registers locally; needs tns_pkg, tns_in_if, tns_out_if
`timescale 1ns / 1ps
module tb_texture_nearest_sampler;
  import tns_pkg::*;

  localparam int          TEX_MAX       = 256;            // default MAX_WIDTH / MAX_HEIGHT
  localparam int          TEXELS        = TEX_MAX * TEX_MAX;
  localparam logic [31:0] Q_ONE         = 32'h0001_0000;  // 1.0 in Q16.16
  localparam logic [1:0]  OP_UNKNOWN    = 2'd3;           // not decoded, dropped by the block
  localparam int          SETTLE_CYCLES = 16;             // request queue + ram + result buffer
  localparam int          IDLE_PCT      = 28;

  // one request as the bench builds it
  typedef struct {
    logic [1:0]         op;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [31:0] cu;
    logic signed [31:0] cv;
    logic [15:0]        blue;
    logic [15:0]        green;
    logic [15:0]        red;
  } texture_req_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } texel_rgb_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [8:0] cfg_data;

  tns_in_if  req_if ();
  tns_out_if res_if ();

  texture_nearest_sampler dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_if      (req_if),
    .out_if     (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // local copy of the register file and the texel store
  logic [8:0] width_reg;
  logic [8:0] height_reg;
  bit         src16_reg;
  texel_rgb_t texture_mirror [TEXELS];
  bit         texel_loaded [TEXELS];

  // texels still owed by the block, oldest first
  texel_rgb_t expected_texels [$];

  // when set, neither side idles
  bit steady_flow;

  int error_count;
  int results_checked;
  int loads_sent;
  int points_sent;
  int nearest_sent;
  int ignored_sent;

  // free running clock, 10 ns
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs or results go missing
  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d texels still expected", $time, expected_texels.size());
    $display("== FAIL ==");
    $finish;
  end

  // result side backpressure, changed on the falling edge
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_if.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // zero size acts as one, anything past the array acts as the array size
  function automatic int unsigned clip_dim(logic [8:0] raw);
    if (raw == 9'd0) return 1;
    if (raw > TEX_MAX) return TEX_MAX;
    return 32'(raw);
  endfunction

  function automatic bit position_inside(logic signed [15:0] px, logic signed [15:0] py);
    int sx;
    int sy;
    sx = int'(px);
    sy = int'(py);
    return sx >= 0 && sy >= 0 && sx < int'(clip_dim(width_reg))
           && sy < int'(clip_dim(height_reg));
  endfunction

  // clamp Q16.16 to [0,1], scale by dim-1, truncate
  function automatic int unsigned nearest_index(logic signed [31:0] c, int unsigned dim);
    logic [31:0] raw;
    logic [63:0] pos;
    raw = c;
    if (raw[31]) raw = '0;
    else if (raw > Q_ONE) raw = Q_ONE;
    pos = (64'(raw) * 64'(dim - 1)) >> 16;
    if (pos >= dim) pos = 64'(dim - 1);
    return 32'(pos);
  endfunction

  // store address a request reads, if it reads one at all
  function automatic bit texel_address(texture_req_t rq, output int unsigned addr);
    addr = 0;
    case (rq.op)
      OP_POINT: begin
        if (position_inside(rq.px, rq.py)) begin
          addr = int'(rq.py) * TEX_MAX + int'(rq.px);
          return 1;
        end
      end
      OP_NEAREST: begin
        addr = nearest_index(rq.cv, clip_dim(height_reg)) * TEX_MAX
               + nearest_index(rq.cu, clip_dim(width_reg));
        return 1;
      end
      default: ;
    endcase
    return 0;
  endfunction

  // 8-bit channels go to unorm16 by c*257, high byte dropped
  function automatic logic [15:0] widen_channel(logic [15:0] c);
    if (src16_reg) return c;
    return 16'(c[7:0]) * 16'd257;
  endfunction

  // advance the mirror by one taken request and queue what it owes
  function automatic void apply_request(texture_req_t rq);
    int unsigned addr;
    case (rq.op)
      OP_LOAD: begin
        loads_sent++;
        if (position_inside(rq.px, rq.py)) begin
          addr = int'(rq.py) * TEX_MAX + int'(rq.px);
          // source order is blue, green, red; store order is red, green, blue
          texture_mirror[addr] = '{red: widen_channel(rq.red), green: widen_channel(rq.green),
                                   blue: widen_channel(rq.blue)};
          texel_loaded[addr] = 1'b1;
        end
      end
      OP_POINT, OP_NEAREST: begin
        if (rq.op == OP_POINT) points_sent++;
        else nearest_sent++;
        // a point outside the texture returns black
        expected_texels.push_back(texel_address(rq, addr) ? texture_mirror[addr] : '0);
      end
      default: ignored_sent++;
    endcase
  endfunction

  function automatic texture_req_t make_req(logic [1:0] op, int px, int py, logic [31:0] cu,
                                            logic [31:0] cv, logic [15:0] blue,
                                            logic [15:0] green, logic [15:0] red);
    texture_req_t rq;
    rq.op    = op;
    rq.px    = 16'(px);
    rq.py    = 16'(py);
    rq.cu    = cu;
    rq.cv    = cv;
    rq.blue  = blue;
    rq.green = green;
    rq.red   = red;
    return rq;
  endfunction

  // load with random content; unused coordinate fields random as well
  function automatic texture_req_t random_load(int unsigned col, int unsigned row);
    return make_req(OP_LOAD, col, row, $urandom, $urandom, 16'($urandom), 16'($urandom),
                    16'($urandom));
  endfunction

  // mostly well-formed traffic inside the current texture, some noise
  function automatic texture_req_t random_request();
    texture_req_t rq;
    int unsigned  kind;
    rq   = random_load($urandom_range(0, clip_dim(width_reg) - 1),
                       $urandom_range(0, clip_dim(height_reg) - 1));
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      // in-range load as built
    end else if (kind < 55) begin
      rq.op = OP_POINT;
    end else if (kind < 80) begin
      // coordinates from -0.25 to 1.25, so both clamps get hit
      rq.op = OP_NEAREST;
      rq.cu = int'($urandom_range(0, 98304)) - 16384;
      rq.cv = int'($urandom_range(0, 98304)) - 16384;
    end else begin
      // any position, full-range coordinates
      rq.op = (kind < 95) ? 2'($urandom_range(0, 2)) : OP_UNKNOWN;
      rq.px = 16'($urandom);
      rq.py = 16'($urandom);
    end
    return rq;
  endfunction

  function automatic logic [8:0] random_dim();
    case ($urandom_range(0, 9))
      0:       return 9'd0;
      1:       return 9'd256;
      2:       return 9'($urandom_range(257, 511));
      default: return 9'($urandom_range(1, 16));
    endcase
  endfunction

  // one request through the handshake; entered and left on a falling edge
  // with valid still up, so back to back requests keep it up unless a random idle drops it
  task automatic drive_request(texture_req_t rq);
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= rq.op;
    req_if.pos_x     <= rq.px;
    req_if.pos_y     <= rq.py;
    req_if.coord_u   <= rq.cu;
    req_if.coord_v   <= rq.cv;
    req_if.src_blue  <= rq.blue;
    req_if.src_green <= rq.green;
    req_if.src_red   <= rq.red;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    apply_request(rq);
    @(negedge clk);
  endtask

  // texels are undefined until loaded: fill the target first if needed
  task automatic issue(texture_req_t rq);
    int unsigned addr;
    if (texel_address(rq, addr) && !texel_loaded[addr]) begin
      drive_request(random_load(addr % TEX_MAX, addr / TEX_MAX));
    end
    drive_request(rq);
  endtask

  // stop sending, wait for every owed texel, then let trailing loads land
  task automatic settle();
    req_if.valid <= 1'b0;
    while (expected_texels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // all three registers in one burst, write enable held across it
  task automatic set_texture(logic [8:0] w, logic [8:0] h, logic [8:0] s);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_WIDTH;
    cfg_data <= w;
    @(negedge clk);
    cfg_idx  <= CFG_HEIGHT;
    cfg_data <= h;
    @(negedge clk);
    cfg_idx  <= CFG_SRC16;
    cfg_data <= s;
    @(negedge clk);
    cfg_we     <= 1'b0;
    width_reg  = w;
    height_reg = h;
    src16_reg  = s[0];
  endtask

  // reset values: 256 x 256, 8-bit source
  task automatic test_default_geometry();
    // 8-bit source with junk in the high bytes
    issue(make_req(OP_LOAD, 0, 0, 0, 0, 16'hFF01, 16'h0080, 16'h12FF));
    issue(make_req(OP_LOAD, 255, 255, -1, -1, 16'hFFFF, 16'h0000, 16'h00FF));
    // loads outside the texture write nothing
    issue(make_req(OP_LOAD, 256, 0, 0, 0, 16'h1111, 16'h2222, 16'h3333));
    issue(make_req(OP_LOAD, -32768, 32767, 0, 0, 16'h4444, 16'h5555, 16'h6666));
    issue(make_req(OP_POINT, 0, 0, 0, 0, 16'h0, 16'h0, 16'h0));
    issue(make_req(OP_POINT, 255, 255, 0, 0, 16'h0, 16'h0, 16'h0));
    // points outside return black
    issue(make_req(OP_POINT, 256, 0, 0, 0, 16'h0, 16'h0, 16'h0));
    issue(make_req(OP_POINT, 0, 256, 0, 0, 16'h0, 16'h0, 16'h0));
    issue(make_req(OP_POINT, -1, 32767, 0, 0, 16'h0, 16'h0, 16'h0));
    // nearest at 0 and 1.0, then both clamps at the extremes of the field
    issue(make_req(OP_NEAREST, 0, 0, 0, 0, 16'h0, 16'h0, 16'h0));
    issue(make_req(OP_NEAREST, 0, 0, Q_ONE, Q_ONE, 16'h0, 16'h0, 16'h0));
    issue(make_req(OP_NEAREST, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0, 16'h0, 16'h0));
    // unknown op over a loaded texel must leave it alone
    issue(make_req(OP_UNKNOWN, 0, 0, -1, -1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    issue(make_req(OP_POINT, 0, 0, 0, 0, 16'h0, 16'h0, 16'h0));
  endtask

  // 16-bit source on a 2 x 2 texture, then clipped sizes
  task automatic test_src16_and_size_clip();
    settle();
    set_texture(9'd2, 9'd2, 9'd1);
    issue(make_req(OP_LOAD, 0, 0, 0, 0, 16'hFFFF, 16'h8000, 16'h0001));
    issue(make_req(OP_LOAD, 1, 0, 0, 0, 16'h1234, 16'h5678, 16'h9ABC));
    issue(make_req(OP_LOAD, 1, 1, 0, 0, 16'h0000, 16'hFFFF, 16'h7FFF));
    // just below 1.0 truncates to texel 0, 1.0 and above lands on the last one
    issue(make_req(OP_NEAREST, 0, 0, Q_ONE - 1, 32'h0000_8000, 16'h0, 16'h0, 16'h0));
    issue(make_req(OP_NEAREST, 0, 0, Q_ONE, Q_ONE + 1, 16'h0, 16'h0, 16'h0));
    issue(make_req(OP_POINT, 2, 1, 0, 0, 16'h0, 16'h0, 16'h0));
    issue(make_req(OP_POINT, 1, 1, 0, 0, 16'h0, 16'h0, 16'h0));
    // width 0 behaves as 1, height past the array as the array height
    settle();
    set_texture(9'd0, 9'h1FF, 9'h1FF);
    issue(make_req(OP_POINT, 1, 0, 0, 0, 16'h0, 16'h0, 16'h0));
    issue(make_req(OP_POINT, 0, 255, 0, 0, 16'h0, 16'h0, 16'h0));
    issue(make_req(OP_NEAREST, 0, 0, Q_ONE, Q_ONE, 16'h0, 16'h0, 16'h0));
  endtask

  // phases of random traffic, each under a fresh size and source setting
  task automatic test_random_traffic(int target);
    texture_req_t rq;
    int           sent;
    int           phase_idx;
    sent      = 0;
    phase_idx = 0;
    while (sent < target) begin
      settle();
      case (phase_idx)
        0:       set_texture(9'd1, 9'd1, 9'd0);
        1:       set_texture(9'd256, 9'd256, 9'd1);
        2:       set_texture(9'h1FF, 9'd0, 9'h1FE);
        default: set_texture(random_dim(), random_dim(), 9'($urandom_range(0, 511)));
      endcase
      repeat (100) begin
        rq = random_request();
        issue(rq);
        if (rq.op != OP_UNKNOWN) sent++;
      end
      phase_idx++;
    end
  endtask

  // long stretch with both sides always willing
  task automatic test_steady_stream(int count);
    settle();
    set_texture(9'd8, 9'd5, 9'd0);
    steady_flow = 1'b1;
    repeat (count) issue(random_request());
    settle();
    steady_flow = 1'b0;
  endtask

  // compare each returned texel with the oldest owed one
  always @(posedge clk) begin : check_results
    texel_rgb_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_texels.size() == 0) begin
        $display("%0t: unexpected result, got r=%h g=%h b=%h", $time, res_if.out_red,
                 res_if.out_green, res_if.out_blue);
        error_count++;
      end else begin
        want = expected_texels.pop_front();
        results_checked++;
        if (res_if.out_red !== want.red) begin
          $display("%0t: out_red expected %h, got %h", $time, want.red, res_if.out_red);
          error_count++;
        end
        if (res_if.out_green !== want.green) begin
          $display("%0t: out_green expected %h, got %h", $time, want.green, res_if.out_green);
          error_count++;
        end
        if (res_if.out_blue !== want.blue) begin
          $display("%0t: out_blue expected %h, got %h", $time, want.blue, res_if.out_blue);
          error_count++;
        end
      end
    end
  end

  initial begin : run_tests
    int wait_cycles;
    // every input known from time zero
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_WIDTH;
    cfg_data         = '0;
    req_if.valid     = 1'b0;
    req_if.operation = OP_LOAD;
    req_if.pos_x     = '0;
    req_if.pos_y     = '0;
    req_if.coord_u   = '0;
    req_if.coord_v   = '0;
    req_if.src_blue  = '0;
    req_if.src_green = '0;
    req_if.src_red   = '0;
    width_reg        = 9'd256;
    height_reg       = 9'd256;
    src16_reg        = 1'b0;
    steady_flow      = 1'b0;
    error_count      = 0;
    results_checked  = 0;
    loads_sent       = 0;
    points_sent      = 0;
    nearest_sent     = 0;
    ignored_sent     = 0;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_default_geometry();
    test_src16_and_size_clip();
    test_random_traffic(850);
    test_steady_stream(150);

    // drain with a bound, anything still owed is a failure
    req_if.valid <= 1'b0;
    wait_cycles = 0;
    while (expected_texels.size() != 0 && wait_cycles < 20000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_texels.size() != 0) begin
      $display("%0t: %0d expected texels never returned", $time, expected_texels.size());
      error_count++;
    end

    $display("sent %0d loads, %0d point and %0d nearest samples, %0d dropped opcodes",
             loads_sent, points_sent, nearest_sent, ignored_sent);
    $display("checked %0d texels over clipped sizes, clamped coords, 8/16-bit sources, %0d errors",
             results_checked, error_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* texture_nearest_sampler.f */
+incdir+rtl
rtl/tns_pkg.sv
rtl/tns_in_if.sv
rtl/tns_out_if.sv
rtl/tns_ram.sv
rtl/tns_fifo.sv
rtl/tns_front.sv
rtl/tns_back.sv
rtl/texture_nearest_sampler.sv
bench/tb_texture_nearest_sampler.sv
